### rtl/sfpr_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the silence-framed ping-pong receiver
// no dependencies

package sfpr_pkg;

  localparam int FRAME_BYTES = 256;
  localparam int STORE_DEPTH = 2 * FRAME_BYTES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [15:0] SILENCE_RESET = 16'd35;
  localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_RX_BYTE = 2'd0,
    OP_TICK    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  localparam logic CAUSE_SILENCE = 1'b0;
  localparam logic CAUSE_FULL    = 1'b1;

endpackage

### rtl/sfpr_in_if.sv
`timescale 1ns / 1ps
// input channel: received bytes, ticks, release and read requests
// stand-alone, no package needed

interface sfpr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_data;
  logic       buffer_sel;
  logic [7:0] read_addr;

  modport source (output valid, operation, rx_data, buffer_sel, read_addr, input ready);
  modport sink   (input valid, operation, rx_data, buffer_sel, read_addr, output ready);
endinterface

### rtl/sfpr_out_if.sv
`timescale 1ns / 1ps
// result channel: frame close report, read data and ready flags
// stand-alone, no package needed

interface sfpr_out_if;
  logic       valid;
  logic       ready;
  logic       frame_done;
  logic       done_buffer;
  logic [8:0] done_length;
  logic       close_cause;
  logic [7:0] read_byte;
  logic [1:0] ready_flags;

  modport source (output valid, frame_done, done_buffer, done_length, close_cause,
                  read_byte, ready_flags, input ready);
  modport sink   (input valid, frame_done, done_buffer, done_length, close_cause,
                  read_byte, ready_flags, output ready);
endinterface

### rtl/silence_framed_pingpong_receiver.sv
`timescale 1ns / 1ps
// the result of a beat is registered and appears in the cycle after it is accepted
// throughput: one beat per cycle; the frame store takes one write and one read a cycle
// and the counters update in that cycle; a result held by the sink stalls the input,
// while a result taken in a cycle makes room for a new beat in the same cycle
// reset: synchronous, clears flags, counters, active half and the silence limit (35);
// the frame store is not cleared and holds nothing defined until written
// depends on sfpr_pkg, sfpr_in_if, sfpr_out_if

module silence_framed_pingpong_receiver (
  input  logic            clk,
  input  logic            rst,
  sfpr_in_if.sink         item,
  sfpr_out_if.source      result,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_data
);

  // frame store, two halves of FRAME_BYTES
  logic [7:0] frame_store [sfpr_pkg::STORE_DEPTH];

  logic                        active_half, active_half_next;
  logic [sfpr_pkg::CNT_W-1:0]  write_count, write_count_next;
  logic [1:0]                  half_ready, half_ready_next;
  logic [15:0]                 silence_count, silence_count_next;
  logic                        timer_running, timer_running_next;
  logic [15:0]                 silence_ticks;

  logic       out_valid;
  logic       frame_done, done_buffer, close_cause;
  logic [8:0] done_length;
  logic       rd_flag;
  logic [7:0] rd_data;

  logic       acc;
  logic       close, cause;
  logic       store_we;
  logic [15:0] cnt_inc;
  logic [31:0] wr_lin, rd_lin;
  logic [sfpr_pkg::STORE_AW-1:0] wr_index, rd_index;
  logic       rd_ok;
  sfpr_pkg::op_t op;

  assign op  = sfpr_pkg::op_t'(item.operation);
  assign acc = item.valid && item.ready;
  assign item.ready = !out_valid || result.ready;

  assign wr_lin   = (active_half ? 32'(sfpr_pkg::FRAME_BYTES) : 32'd0) + 32'(write_count);
  assign wr_index = wr_lin[sfpr_pkg::STORE_AW-1:0];
  assign rd_lin   = (item.buffer_sel ? 32'(sfpr_pkg::FRAME_BYTES) : 32'd0)
                    + 32'(item.read_addr);
  assign rd_index = rd_lin[sfpr_pkg::STORE_AW-1:0];
  assign rd_ok    = 32'(item.read_addr) < 32'(sfpr_pkg::FRAME_BYTES);

  assign cnt_inc = (silence_count != sfpr_pkg::SILENCE_MAX) ? silence_count + 16'd1
                                                            : silence_count;

  always_comb begin
    active_half_next   = active_half;
    write_count_next   = write_count;
    half_ready_next    = half_ready;
    silence_count_next = silence_count;
    timer_running_next = timer_running;
    close    = 1'b0;
    cause    = sfpr_pkg::CAUSE_SILENCE;
    store_we = 1'b0;
    if (acc) begin
      unique case (op)
        sfpr_pkg::OP_RX_BYTE: begin
          if (32'(write_count) >= 32'(sfpr_pkg::FRAME_BYTES)) begin
            close = 1'b1;
            cause = sfpr_pkg::CAUSE_FULL;
          end else begin
            store_we         = 1'b1;
            write_count_next = write_count + 1'b1;
            // first byte of a frame only stops the timer
            if (write_count == '0) begin
              timer_running_next = 1'b0;
            end else begin
              silence_count_next = '0;
              timer_running_next = 1'b1;
            end
          end
        end
        sfpr_pkg::OP_TICK: begin
          if (timer_running) begin
            silence_count_next = cnt_inc;
            if (cnt_inc >= silence_ticks) begin
              close = 1'b1;
            end
          end
        end
        sfpr_pkg::OP_RELEASE: begin
          half_ready_next[item.buffer_sel] = 1'b0;
        end
        sfpr_pkg::OP_READ: begin
        end
        default: begin
        end
      endcase
      if (close) begin
        half_ready_next[active_half] = 1'b1;
        active_half_next   = !active_half;
        write_count_next   = '0;
        timer_running_next = 1'b0;
        silence_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_half   <= 1'b0;
      write_count   <= '0;
      half_ready    <= '0;
      silence_count <= '0;
      timer_running <= 1'b0;
      silence_ticks <= sfpr_pkg::SILENCE_RESET;
      out_valid     <= 1'b0;
    end else begin
      active_half   <= active_half_next;
      write_count   <= write_count_next;
      half_ready    <= half_ready_next;
      silence_count <= silence_count_next;
      timer_running <= timer_running_next;
      if (cfg_we) begin
        silence_ticks <= cfg_data;
      end
      if (acc) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted beat
  always_ff @(posedge clk) begin
    if (acc) begin
      frame_done  <= close;
      done_buffer <= close ? active_half : 1'b0;
      done_length <= close ? 9'(write_count) : 9'd0;
      close_cause <= close ? cause : sfpr_pkg::CAUSE_SILENCE;
      rd_flag     <= (op == sfpr_pkg::OP_READ) && rd_ok;
    end
  end

  // store port: read data held until the next beat replaces the result
  always_ff @(posedge clk) begin
    if (store_we) begin
      frame_store[wr_index] <= item.rx_data;
    end
    if (acc) begin
      rd_data <= frame_store[rd_index];
    end
  end

  assign result.valid       = out_valid;
  assign result.frame_done  = frame_done;
  assign result.done_buffer = done_buffer;
  assign result.done_length = done_length;
  assign result.close_cause = close_cause;
  assign result.read_byte   = rd_flag ? rd_data : 8'd0;
  assign result.ready_flags = half_ready;

`ifndef SYNTH
  // the timer only runs once a frame holds two or more bytes
  a_timer_needs_two: assert property (@(posedge clk) disable iff (rst)
    timer_running |-> (32'(write_count) >= 32'd2))
    else $error("silence timer running on a frame shorter than two bytes");

  // every close swaps the active half
  a_close_swaps: assert property (@(posedge clk) disable iff (rst)
    close |=> (active_half != $past(active_half)))
    else $error("frame closed without swapping halves");

  // a stored byte advances the fill count by one
  a_write_advances: assert property (@(posedge clk) disable iff (rst)
    store_we |=> (32'(write_count) == 32'($past(write_count)) + 32'd1))
    else $error("fill count did not advance on a stored byte");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for silence_framed_pingpong_receiver: random and directed frames,
// ticks, releases and reads, checked beat by beat against an in-bench frame predictor
// depends on sfpr_pkg, sfpr_in_if, sfpr_out_if and the receiver rtl

module testbench;

  localparam int STUCK_LIMIT = 5000;
  localparam int QUEUE_AHEAD = 8;

  typedef struct packed {
    sfpr_pkg::op_t operation;
    logic [7:0]    rx_data;
    logic          buffer_sel;
    logic [7:0]    read_addr;
  } rx_beat_t;

  typedef struct packed {
    logic       frame_done;
    logic       done_buffer;
    logic [8:0] done_length;
    logic       close_cause;
    logic [7:0] read_byte;
    logic [1:0] ready_flags;
  } frame_report_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_data;

  sfpr_in_if  item_ch ();
  sfpr_out_if res_ch ();

  silence_framed_pingpong_receiver uut (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch),
    .result   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // predictor state
  logic [7:0]                 frame_mem [sfpr_pkg::STORE_DEPTH];
  logic                       active_half;
  logic [sfpr_pkg::CNT_W-1:0] fill_count;
  logic [1:0]                 half_ready;
  logic [15:0]                quiet_count;
  logic                       timer_on;
  logic [15:0]                silence_limit;
  int unsigned                stored_hi [2];

  rx_beat_t      beats_pending [$];
  frame_report_t reports_due [$];
  int unsigned   beats_posted;
  int unsigned   beats_outstanding;
  int unsigned   reports_taken;
  int unsigned   mismatches;
  int unsigned   stuck_cycles;
  int unsigned   send_idle_pct;
  int unsigned   take_idle_pct;
  int unsigned   plan_limit;
  int unsigned   hold_left;
  logic          squeeze_done;
  logic          beat_taken;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic frame_report_t close_frame(input logic cause);
    frame_report_t r;
    r = '0;
    r.frame_done  = 1'b1;
    r.done_buffer = active_half;
    r.done_length = fill_count;
    r.close_cause = cause;
    half_ready[active_half] = 1'b1;
    active_half = ~active_half;
    fill_count  = '0;
    timer_on    = 1'b0;
    quiet_count = '0;
    return r;
  endfunction

  function automatic frame_report_t deframe_step(input rx_beat_t b);
    frame_report_t r;
    r = '0;
    case (b.operation)
      sfpr_pkg::OP_RX_BYTE: begin
        if (fill_count >= sfpr_pkg::FRAME_BYTES) begin
          // byte hits a full half: close and drop it
          r = close_frame(sfpr_pkg::CAUSE_FULL);
        end else begin
          frame_mem[int'(active_half) * sfpr_pkg::FRAME_BYTES + int'(fill_count)] = b.rx_data;
          fill_count = fill_count + 1'b1;
          if (32'(fill_count) > stored_hi[active_half])
            stored_hi[active_half] = 32'(fill_count);
          // first byte of a frame only stops the timer
          if (fill_count == 1) begin
            timer_on = 1'b0;
          end else begin
            quiet_count = '0;
            timer_on    = 1'b1;
          end
        end
      end
      sfpr_pkg::OP_TICK: begin
        if (timer_on) begin
          if (quiet_count != sfpr_pkg::SILENCE_MAX) quiet_count = quiet_count + 1'b1;
          if (quiet_count >= silence_limit) r = close_frame(sfpr_pkg::CAUSE_SILENCE);
        end
      end
      sfpr_pkg::OP_RELEASE: begin
        half_ready[b.buffer_sel] = 1'b0;
      end
      default: begin
        if (b.read_addr < sfpr_pkg::FRAME_BYTES)
          r.read_byte = frame_mem[int'(b.buffer_sel) * sfpr_pkg::FRAME_BYTES
                                  + int'(b.read_addr)];
      end
    endcase
    r.ready_flags = half_ready;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // monitor: predicts on every accepted input beat, checks every result beat
  always @(posedge clk) begin
    rx_beat_t      seen;
    frame_report_t want;
    beat_taken = 1'b0;
    if (rst) begin
      active_half   = 1'b0;
      fill_count    = '0;
      half_ready    = '0;
      quiet_count   = '0;
      timer_on      = 1'b0;
      silence_limit = sfpr_pkg::SILENCE_RESET;
      stored_hi[0]  = 0;
      stored_hi[1]  = 0;
      stuck_cycles  = 0;
    end else begin
      if (cfg_we) silence_limit = cfg_data;
      if (item_ch.valid && item_ch.ready) begin
        seen.operation  = sfpr_pkg::op_t'(item_ch.operation);
        seen.rx_data    = item_ch.rx_data;
        seen.buffer_sel = item_ch.buffer_sel;
        seen.read_addr  = item_ch.read_addr;
        reports_due.push_back(deframe_step(seen));
        beats_outstanding--;
        beat_taken = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        reports_taken++;
        if (reports_due.size() == 0) begin
          $error("result beat with no expectation waiting");
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          check_field("frame_done", 16'(want.frame_done), 16'(res_ch.frame_done));
          check_field("done_buffer", 16'(want.done_buffer), 16'(res_ch.done_buffer));
          check_field("done_length", 16'(want.done_length), 16'(res_ch.done_length));
          check_field("close_cause", 16'(want.close_cause), 16'(res_ch.close_cause));
          check_field("read_byte", 16'(want.read_byte), 16'(res_ch.read_byte));
          check_field("ready_flags", 16'(want.ready_flags), 16'(res_ch.ready_flags));
        end
      end
      if (beat_taken || (res_ch.valid && res_ch.ready)) stuck_cycles = 0;
      else stuck_cycles++;
    end
  end

  // driver: valid stays up across back-to-back beats
  always @(negedge clk) begin
    rx_beat_t nb;
    if (!item_ch.valid || beat_taken) begin
      if (beats_pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nb = beats_pending.pop_front();
        item_ch.valid      <= 1'b1;
        item_ch.operation  <= nb.operation;
        item_ch.rx_data    <= nb.rx_data;
        item_ch.buffer_sel <= nb.buffer_sel;
        item_ch.read_addr  <= nb.read_addr;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  // receiver side, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!squeeze_done && reports_taken >= 200) begin
      res_ch.ready <= 1'b0;
      hold_left    <= 400;
      squeeze_done <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
    end
  end

  always @(negedge clk) begin
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic post_beat(input sfpr_pkg::op_t op, input logic [7:0] data,
                           input logic sel, input logic [7:0] addr);
    rx_beat_t b;
    while (beats_pending.size() >= QUEUE_AHEAD) @(negedge clk);
    b.operation  = op;
    b.rx_data    = data;
    b.buffer_sel = sel;
    b.read_addr  = addr;
    beats_pending.push_back(b);
    beats_posted++;
    beats_outstanding++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) post_beat(sfpr_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic send_byte(input logic [7:0] data);
    post_beat(sfpr_pkg::OP_RX_BYTE, data, 1'($urandom_range(0, 1)),
              8'($urandom_range(0, 255)));
  endtask

  // only bytes already stored are read; the written region of a half never shrinks
  task automatic send_read();
    logic sel;
    sel = 1'($urandom_range(0, 1));
    if (stored_hi[sel] == 0) sel = ~sel;
    if (stored_hi[sel] == 0)
      send_ticks(1);
    else
      post_beat(sfpr_pkg::OP_READ, 8'($urandom_range(0, 255)), sel,
                8'($urandom_range(0, stored_hi[sel] - 1)));
  endtask

  task automatic send_frame(input int unsigned len);
    repeat (len) begin
      send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 6) send_read();
    end
    if (len == sfpr_pkg::FRAME_BYTES) send_byte(8'($urandom_range(0, 255)));
    if (plan_limit <= 40) send_ticks(plan_limit + $urandom_range(0, 2));
    else send_ticks($urandom_range(1, 6));
  endtask

  task automatic random_traffic(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = beats_posted + count;
    while (beats_posted < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) send_frame(1);
        else if (pick < 10) send_frame(sfpr_pkg::FRAME_BYTES);
        else send_frame($urandom_range(2, 12));
      end else if (pick < 80) begin
        send_read();
      end else if (pick < 88) begin
        post_beat(sfpr_pkg::OP_RELEASE, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
        // noise: stray bytes, ticks and releases
        post_beat(sfpr_pkg::op_t'(2'($urandom_range(0, 2))), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic settle();
    while (beats_outstanding != 0 || reports_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_limit(input logic [15:0] value);
    settle();
    cfg_we     = 1'b1;
    cfg_data   = value;
    plan_limit = 32'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_data           = '0;
    item_ch.valid      = 1'b0;
    item_ch.operation  = sfpr_pkg::OP_RX_BYTE;
    item_ch.rx_data    = '0;
    item_ch.buffer_sel = 1'b0;
    item_ch.read_addr  = '0;
    res_ch.ready       = 1'b0;
    beats_posted       = 0;
    beats_outstanding  = 0;
    reports_taken      = 0;
    mismatches         = 0;
    stuck_cycles       = 0;
    hold_left          = 0;
    squeeze_done       = 1'b0;
    beat_taken         = 1'b0;
    send_idle_pct      = 32;
    take_idle_pct      = 68;
    plan_limit         = 32'(sfpr_pkg::SILENCE_RESET);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset limit; stopped timer, idle releases, single-byte frame left open
    send_ticks(1);
    post_beat(sfpr_pkg::OP_RELEASE, 8'h00, 1'b0, 8'h00);
    post_beat(sfpr_pkg::OP_RELEASE, 8'hFF, 1'b1, 8'hFF);
    send_byte(8'h00);
    send_ticks(3);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_ticks(35);
    post_beat(sfpr_pkg::OP_READ, 8'h00, 1'b0, 8'd0);
    post_beat(sfpr_pkg::OP_READ, 8'h00, 1'b0, 8'd1);
    post_beat(sfpr_pkg::OP_READ, 8'h00, 1'b0, 8'd2);
    post_beat(sfpr_pkg::OP_RELEASE, 8'h00, 1'b0, 8'h00);

    // zero limit closes on the first tick, then a full half with its byte dropped
    set_limit(16'd0);
    send_byte(8'h3C);
    send_byte(8'hC3);
    send_ticks(1);
    repeat (sfpr_pkg::FRAME_BYTES + 1) send_byte(8'($urandom_range(0, 255)));
    post_beat(sfpr_pkg::OP_READ, 8'h00, 1'b0, 8'd255);
    post_beat(sfpr_pkg::OP_READ, 8'h00, 1'b0, 8'd128);
    random_traffic(65);

    set_limit(16'd1);
    random_traffic(65);

    send_idle_pct = 68;
    take_idle_pct = 32;
    set_limit(16'($urandom_range(2, 6)));
    random_traffic(65);

    set_limit(16'hFFFF);
    random_traffic(55);

    send_idle_pct = 0;
    take_idle_pct = 0;
    set_limit(16'($urandom_range(7, 40)));
    random_traffic(65);

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sfpr_pkg.sv
rtl/sfpr_in_if.sv
rtl/sfpr_out_if.sv
rtl/silence_framed_pingpong_receiver.sv
test/testbench.sv
